// File: hw/rtl/life_pkg.sv
`default_nettype none
package life_pkg;
  localparam int MaxWidth = 64;
  localparam int MaxHeight = 64;
  localparam int CellCount = MaxWidth * MaxHeight;
  localparam int AddrW = $clog2(CellCount);
  localparam int XW = $clog2(MaxWidth);
  localparam int YW = $clog2(MaxHeight);
  // neighbor window: two storage rows plus two cells
  localparam int WinLen = 2 * MaxWidth + 2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;
endpackage
`default_nettype wire

// File: hw/rtl/life_cell.sv
`default_nettype none
// One window cell; hands its bit to the next cell along the chain each cycle that shift is high.
module life_cell (
  input  wire logic clk,
  input  wire logic shift,
  input  wire logic clear,
  input  wire logic d,
  output logic      q
);
  always_ff @(posedge clk) begin
    if (clear) begin
      q <= 1'b0;
    end else if (shift) begin
      q <= d;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/life_automaton_step_top.sv
`default_nettype none
// Write (and none): result beat valid the cycle after acceptance; read: S_RD, then the beat.
// Step: one live-bank read a cycle in raster order through a chain of 2*MaxWidth+2 cells;
// the sweep runs cnt from 0 through CellCount+MaxWidth+1, then the result beat follows.
// One item at a time: in_stall stays high until the result beat is taken.
// rst clears control state, the live bank select and sets both sizes to 64; a clearing
// pass over all CellCount cells of both banks follows reset, with in_stall high.
module life_automaton_step_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] opcode,
  input  wire logic [5:0] cell_x,
  input  wire logic [5:0] cell_y,
  input  wire logic       cell_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            cell_out,
  output logic            op_done,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [6:0] cfg_data
);
  localparam int AW = life_pkg::AddrW;
  localparam int XW = life_pkg::XW;
  localparam int YW = life_pkg::YW;
  localparam int W = life_pkg::MaxWidth;
  localparam int NW = life_pkg::WinLen;

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_RD   = 5'b00100,
    S_STEP = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [6:0] grid_width, grid_height;
  logic live_bank;
  logic [AW-1:0] clr_addr;

  logic mem_a [life_pkg::CellCount];
  logic mem_b [life_pkg::CellCount];

  logic [XW:0] w_used, h_used;
  always_comb begin
    w_used = (grid_width == 7'd0) ? (XW+1)'(1) :
             (grid_width > 7'(life_pkg::MaxWidth)) ? (XW+1)'(life_pkg::MaxWidth) :
             grid_width[XW:0];
    h_used = (grid_height == 7'd0) ? (YW+1)'(1) :
             (grid_height > 7'(life_pkg::MaxHeight)) ? (YW+1)'(life_pkg::MaxHeight) :
             grid_height[YW:0];
  end

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= 7'd64;
      grid_height <= 7'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        life_pkg::CFG_WIDTH:  grid_width <= cfg_data;
        life_pkg::CFG_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // sweep counter: read position in raster order over the whole storage
  logic [AW:0] cnt;
  logic in_grid, accept;
  logic [1:0] op_q;
  logic res_cell, res_done;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign in_grid = ({1'b0, cell_x} < w_used) && ({1'b0, cell_y} < h_used);

  logic [AW-1:0] a_in, ra;
  assign a_in = {cell_y, cell_x};
  assign ra = (state == S_STEP) ? cnt[AW-1:0] : a_in;
  logic rv_next;
  assign rv_next = (state == S_STEP) && !cnt[AW] &&
                   ({1'b0, cnt[XW-1:0]} < w_used) && ({1'b0, cnt[AW-1:XW]} < h_used);

  logic r_q, rv_q;
  always_ff @(posedge clk) begin
    r_q <= live_bank ? mem_b[ra] : mem_a[ra];
    rv_q <= rv_next;
  end

  // window chain: win[0] newest; c_in holds position cnt-1, win[k] position cnt-2-k
  logic c_in;
  logic shift, wclear;
  logic [NW-1:0] win, win_d;
  assign c_in = r_q & rv_q;
  assign win_d = {win[NW-2:0], c_in};
  for (genvar k = 0; k < NW; k++) begin : g_win
    life_cell u_cell (.clk(clk), .shift(shift), .clear(wclear), .d(win_d[k]), .q(win[k]));
  end

  // center cell is position cnt-W-2, held in win[W]
  logic [AW:0] ctr;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  assign ctr = cnt - (AW+1)'(W + 2);
  assign cx = ctr[XW-1:0];
  assign cy = ctr[AW-1:XW];
  logic lft, rgt;
  assign lft = (cx != '0);
  assign rgt = (cx != '1);

  logic [3:0] n;
  logic nv;
  always_comb begin
    n = 4'(win[W+1] & lft) + 4'(win[2*W+1] & lft) + 4'(win[1] & lft)
      + 4'(win[W-1] & rgt) + 4'(win[2*W-1] & rgt) + 4'(c_in & rgt)
      + 4'(win[2*W]) + 4'(win[0]);
    nv = win[W] ? (n == 4'd2 || n == 4'd3) : (n == 4'd3);
  end
  logic wr_step;
  assign wr_step = (state == S_STEP) && (cnt >= (AW+1)'(W + 2));
  logic [AW-1:0] a_wr;
  assign a_wr = ctr[AW-1:0];
  logic wr_val;
  assign wr_val = nv && ({1'b0, cx} < w_used) && ({1'b0, cy} < h_used);

  always_ff @(posedge clk) begin
    if (state == S_CLR) begin
      mem_a[clr_addr] <= 1'b0;
      mem_b[clr_addr] <= 1'b0;
    end else if (wr_step) begin
      if (live_bank) mem_a[a_wr] <= wr_val;
      else mem_b[a_wr] <= wr_val;
    end else if (accept && opcode == life_pkg::OP_WRITE && in_grid) begin
      if (live_bank) mem_b[a_in] <= cell_in;
      else mem_a[a_in] <= cell_in;
    end
  end

  logic step_end;
  assign step_end = (cnt == (AW+1)'(life_pkg::CellCount + W + 1));
  assign shift = (state == S_STEP);
  assign wclear = (state == S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:  if (clr_addr == AW'(life_pkg::CellCount - 1)) state_next = S_IDLE;
      S_IDLE: if (accept) state_next = (opcode == life_pkg::OP_STEP) ? S_STEP :
                                       (opcode == life_pkg::OP_READ) ? S_RD : S_OUT;
      S_RD:   state_next = S_OUT;
      S_STEP: if (step_end) state_next = S_OUT;
      S_OUT:  if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      live_bank <= 1'b0;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLR) clr_addr <= clr_addr + 1'b1;
      if (state == S_IDLE) begin
        cnt <= '0;
      end else if (state == S_STEP) begin
        cnt <= cnt + 1'b1;
        if (step_end) live_bank <= ~live_bank;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= opcode;
      res_cell <= 1'b0;
      res_done <= (opcode != life_pkg::OP_NONE);
      if (opcode == life_pkg::OP_READ) res_cell <= in_grid;
    end else if (state == S_RD) begin
      res_cell <= res_cell & r_q;
    end
  end

  assign out_valid = (state == S_OUT);
  assign cell_out = res_cell & (op_q == life_pkg::OP_READ);
  assign op_done = res_done;
endmodule
`default_nettype wire

// File: test/tb_life_automaton_step_top.sv
`default_nettype none
module tb_life_automaton_step_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 60000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] opcode;
  logic [5:0] cell_x;
  logic [5:0] cell_y;
  logic cell_in;
  logic out_valid;
  logic out_stall;
  logic cell_out;
  logic op_done;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [6:0] cfg_data;

  life_automaton_step_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .cell_x(cell_x), .cell_y(cell_y), .cell_in(cell_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .cell_out(cell_out), .op_done(op_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic cell_out;
    logic op_done;
  } cell_result_t;

  typedef struct {
    life_pkg::op_t op;
    logic [5:0] x;
    logic [5:0] y;
    logic v;
    logic typed;
    cell_result_t want;
  } life_cmd_t;

  // shadow grid
  bit board_a [life_pkg::CellCount];
  bit board_b [life_pkg::CellCount];
  bit live_is_b;
  logic [6:0] width_reg;
  logic [6:0] height_reg;

  cell_result_t pending_results[$];
  int mismatches;
  int idle_cycles;
  bit timed_out;

  function automatic int span(logic [6:0] r, int lim);
    if (r == 0) return 1;
    if (r > lim) return lim;
    return r;
  endfunction

  function automatic bit live_cell(int x, int y, int w, int h);
    if (x < 0 || y < 0 || x >= w || y >= h) return 0;
    return live_is_b ? board_b[y * life_pkg::MaxWidth + x]
                     : board_a[y * life_pkg::MaxWidth + x];
  endfunction

  function automatic void run_generation();
    int w;
    int h;
    int n;
    bit nxt [life_pkg::CellCount];
    bit alive;
    w = span(width_reg, life_pkg::MaxWidth);
    h = span(height_reg, life_pkg::MaxHeight);
    for (int i = 0; i < life_pkg::CellCount; i++) nxt[i] = 0;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        n = 0;
        for (int dy = -1; dy <= 1; dy++)
          for (int dx = -1; dx <= 1; dx++)
            if (dx != 0 || dy != 0) n += live_cell(x + dx, y + dy, w, h);
        alive = live_cell(x, y, w, h);
        nxt[y * life_pkg::MaxWidth + x] = alive ? (n == 2 || n == 3) : (n == 3);
      end
    if (live_is_b) board_a = nxt;
    else board_b = nxt;
    live_is_b = !live_is_b;
  endfunction

  function automatic cell_result_t predict_cell_op(life_pkg::op_t op, int x, int y, bit v);
    cell_result_t r;
    bit in_grid;
    in_grid = x < span(width_reg, life_pkg::MaxWidth) &&
              y < span(height_reg, life_pkg::MaxHeight);
    r = '{cell_out: 1'b0, op_done: 1'b1};
    case (op)
      life_pkg::OP_WRITE: begin
        if (in_grid) begin
          if (live_is_b) board_b[y * life_pkg::MaxWidth + x] = v;
          else board_a[y * life_pkg::MaxWidth + x] = v;
        end
      end
      life_pkg::OP_READ: begin
        if (in_grid) r.cell_out = live_cell(x, y, life_pkg::MaxWidth, life_pkg::MaxHeight);
      end
      life_pkg::OP_STEP: run_generation();
      default: r.op_done = 1'b0;
    endcase
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (in_valid && !in_stall || out_valid && !out_stall || cfg_valid && cfg_ready)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // random back-pressure on the result side
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 3) == 0)
        out_stall <= ($urandom_range(0, 9) == 0) ? 1'b1 : ~out_stall;
      else
        out_stall <= ($urandom_range(0, 19) == 0) ? 1'b1 : 1'b0;
    end
  end

  always @(posedge clk) begin
    cell_result_t got;
    cell_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{cell_out: cell_out, op_done: op_done};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: cell_out=%0b op_done=%0b",
                                       got.cell_out, got.op_done);
      end else begin
        want = pending_results.pop_front();
        if (got.cell_out !== want.cell_out || got.op_done !== want.op_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: cell_out exp %0b got %0b, op_done exp %0b got %0b",
                     want.cell_out, got.cell_out, want.op_done, got.op_done);
        end
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_cmd(life_cmd_t c);
    cell_result_t want;
    @(posedge clk);
    if ($urandom_range(0, 2) != 0) idle_gap();
    in_valid <= 1'b1;
    opcode <= c.op;
    cell_x <= c.x;
    cell_y <= c.y;
    cell_in <= c.v;
    do @(posedge clk); while (in_stall);
    want = predict_cell_op(c.op, c.x, c.y, c.v);
    if (c.typed && want !== c.want) begin
      mismatches++;
      if (mismatches <= 10) $display("shadow grid disagrees with typed row");
    end
    pending_results.push_back(c.typed ? c.want : want);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (life_pkg::MaxWidth * life_pkg::MaxHeight + life_pkg::MaxWidth + 20)
      @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == life_pkg::CFG_WIDTH) width_reg = val;
    else height_reg = val;
    @(posedge clk);
  endtask

  task automatic random_cmd(int w, int h);
    life_cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    c.typed = 0;
    c.want = '0;
    c.v = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      c.x = 6'($urandom);
      c.y = 6'($urandom);
    end else begin
      c.x = 6'($urandom_range(0, w - 1));
      c.y = 6'($urandom_range(0, h - 1));
    end
    if (pick < 55) begin
      c.op = life_pkg::OP_WRITE;
      c.v = ($urandom_range(0, 2) != 0);
    end else if (pick < 85) c.op = life_pkg::OP_READ;
    else if (pick < 96) c.op = life_pkg::OP_STEP;
    else c.op = life_pkg::OP_NONE;
    send_cmd(c);
  endtask

  life_cmd_t directed [$];
  logic [6:0] width_plan [5] = '{7'd8, 7'd0, 7'd127, 7'd64, 7'd5};
  logic [6:0] height_plan [5] = '{7'd6, 7'd1, 7'd70, 7'd3, 7'd64};

  initial begin
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 0;
    for (int i = 0; i < life_pkg::CellCount; i++) begin
      board_a[i] = 0;
      board_b[i] = 0;
    end
    live_is_b = 0;
    width_reg = 7'd64;
    height_reg = 7'd64;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = life_pkg::OP_WRITE;
    cell_x = '0;
    cell_y = '0;
    cell_in = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = life_pkg::CFG_WIDTH;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: blinker and block at the corners of the full grid
    directed = '{
      '{life_pkg::OP_READ, 6'd63, 6'd63, 1'b0, 1'b1, '{1'b0, 1'b1}},
      '{life_pkg::OP_READ, 6'd0, 6'd0, 1'b0, 1'b1, '{1'b0, 1'b1}},
      '{life_pkg::OP_NONE, 6'd63, 6'd0, 1'b1, 1'b1, '{1'b0, 1'b0}},
      '{life_pkg::OP_WRITE, 6'd63, 6'd63, 1'b1, 1'b1, '{1'b0, 1'b1}},
      '{life_pkg::OP_READ, 6'd63, 6'd63, 1'b0, 1'b1, '{1'b1, 1'b1}},
      '{life_pkg::OP_WRITE, 6'd62, 6'd63, 1'b1, 1'b0, '0},
      '{life_pkg::OP_WRITE, 6'd63, 6'd62, 1'b1, 1'b0, '0},
      '{life_pkg::OP_WRITE, 6'd62, 6'd62, 1'b1, 1'b0, '0},
      '{life_pkg::OP_WRITE, 6'd0, 6'd1, 1'b1, 1'b0, '0},
      '{life_pkg::OP_WRITE, 6'd1, 6'd1, 1'b1, 1'b0, '0},
      '{life_pkg::OP_WRITE, 6'd2, 6'd1, 1'b1, 1'b0, '0},
      '{life_pkg::OP_WRITE, 6'd40, 6'd0, 1'b1, 1'b0, '0},
      '{life_pkg::OP_STEP, 6'd0, 6'd0, 1'b0, 1'b1, '{1'b0, 1'b1}},
      '{life_pkg::OP_READ, 6'd1, 6'd0, 1'b0, 1'b0, '0},
      '{life_pkg::OP_READ, 6'd0, 6'd1, 1'b0, 1'b0, '0},
      '{life_pkg::OP_READ, 6'd1, 6'd2, 1'b0, 1'b0, '0},
      '{life_pkg::OP_READ, 6'd63, 6'd63, 1'b0, 1'b0, '0},
      '{life_pkg::OP_READ, 6'd40, 6'd0, 1'b0, 1'b0, '0},
      '{life_pkg::OP_STEP, 6'd21, 6'd42, 1'b1, 1'b0, '0},
      '{life_pkg::OP_READ, 6'd1, 6'd1, 1'b0, 1'b0, '0},
      '{life_pkg::OP_WRITE, 6'd21, 6'd42, 1'b0, 1'b0, '0},
      '{life_pkg::OP_READ, 6'd62, 6'd62, 1'b0, 1'b0, '0}
    };
    foreach (directed[i]) send_cmd(directed[i]);
    drain();

    // resized grids: out-of-range cells, clamped sizes, resize keeps addresses
    foreach (width_plan[p]) begin
      write_reg(life_pkg::CFG_WIDTH, width_plan[p]);
      write_reg(life_pkg::CFG_HEIGHT, height_plan[p]);
      for (int k = 0; k < 24; k++)
        random_cmd(span(width_reg, life_pkg::MaxWidth), span(height_reg, life_pkg::MaxHeight));
      drain();
    end

    if (timed_out == 0) begin
      if (mismatches == 0 && pending_results.size() == 0)
        $display("life_automaton_step_top verification clean");
      else
        $display("life_automaton_step_top verification failed");
      $finish;
    end
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit);
    timed_out = 1;
    $display("life_automaton_step_top verification failed");
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
hw/rtl/life_pkg.sv
hw/rtl/life_cell.sv
hw/rtl/life_automaton_step_top.sv
test/tb_life_automaton_step_top.sv
